/* rtl/imu_ca_pkg.sv */
// ----------------------------------------------------------------------------
// imu_ca_pkg
// Shared types, constants and the CORDIC angle table of the attitude filter.
// ----------------------------------------------------------------------------
package imu_ca_pkg;

    localparam int CAL_SAMPLES_DEF = 200;
    localparam int CORDIC_STEPS    = 23;
    localparam int CW              = 34;   // CORDIC x/y width
    localparam int ZW              = 28;   // CORDIC angle width
    localparam int AW              = 72;   // serial unit accumulator width
    localparam int BW              = 32;   // multiplier operand width
    localparam int DVW             = 27;   // divisor width
    localparam int ADDR_W          = 3;

    localparam logic [16:0]          ALPHA_RESET = 17'd64225;
    localparam logic [16:0]          ALPHA_ONE   = 17'd65536;
    localparam logic [31:0]          STEP_RESET  = 32'd100000;
    localparam logic [DVW-1:0]       RATE_DIV    = 27'd131000000;
    localparam logic [DVW-1:0]       RATE_HALF   = 27'd65500000;
    localparam logic [15:0]          INV_GAIN    = 16'd39798;
    localparam logic signed [ZW-1:0] DEG180      = 28'sd11796480;

    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_STEP  = 1'b1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [31:0] elapsed_us;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] yaw_angle;
        logic               calibrating;
        logic               step_taken;
        logic               tilt_updated;
    } result_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctl_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = 28'sd2949120;
            5'd1:    v = 28'sd1740967;
            5'd2:    v = 28'sd919879;
            5'd3:    v = 28'sd466945;
            5'd4:    v = 28'sd234379;
            5'd5:    v = 28'sd117304;
            5'd6:    v = 28'sd58666;
            5'd7:    v = 28'sd29335;
            5'd8:    v = 28'sd14668;
            5'd9:    v = 28'sd7334;
            5'd10:   v = 28'sd3667;
            5'd11:   v = 28'sd1833;
            5'd12:   v = 28'sd917;
            5'd13:   v = 28'sd458;
            5'd14:   v = 28'sd229;
            5'd15:   v = 28'sd115;
            5'd16:   v = 28'sd57;
            5'd17:   v = 28'sd29;
            5'd18:   v = 28'sd14;
            5'd19:   v = 28'sd7;
            5'd20:   v = 28'sd4;
            5'd21:   v = 28'sd2;
            5'd22:   v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/imu_ca_stream_if.sv */
// ----------------------------------------------------------------------------
// imu_ca_stream_if
// Valid/ready request channel carrying one payload.
// ----------------------------------------------------------------------------
interface imu_ca_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/imu_ca_muldiv.sv */
// ----------------------------------------------------------------------------
// imu_ca_muldiv
// Bit-serial unit: signed-by-unsigned shift-add multiply (MSB first) or
// restoring unsigned divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module imu_ca_muldiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  imu_ca_pkg::md_ctl_t        ctl,
    input  logic [imu_ca_pkg::AW-1:0]  op_a,
    input  logic [imu_ca_pkg::BW-1:0]  op_b,
    output logic [imu_ca_pkg::AW-1:0]  result,
    output logic                       done
);
    import imu_ca_pkg::*;

    localparam int CNTW = $clog2(AW + 1);
    localparam logic [CNTW-1:0] MUL_STEPS = CNTW'(BW);
    localparam logic [CNTW-1:0] DIV_STEPS = CNTW'(AW);

    logic            busy_reg,  busy_next;
    logic            div_reg,   div_next;
    logic            done_reg,  done_next;
    logic [CNTW-1:0] cnt_reg,   cnt_next;
    logic [AW-1:0]   acc_reg,   acc_next;
    logic [AW-1:0]   mc_reg,    mc_next;
    logic [BW-1:0]   b_reg,     b_next;
    logic [DVW-1:0]  rem_reg,   rem_next;
    logic [DVW:0]    trial;
    logic            fits;

    always_comb
    begin
        trial     = {rem_reg, acc_reg[AW-1]};
        fits      = trial >= {1'b0, b_reg[DVW-1:0]};
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            div_next  = ctl.is_div;
            b_next    = op_b;
            rem_next  = '0;
            if (ctl.is_div)
            begin
                acc_next = op_a;
                cnt_next = DIV_STEPS;
            end
            else
            begin
                acc_next = '0;
                mc_next  = op_a;
                cnt_next = MUL_STEPS;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (div_reg)
            begin
                rem_next = fits ? DVW'(trial - {1'b0, b_reg[DVW-1:0]}) : trial[DVW-1:0];
                acc_next = {acc_reg[AW-2:0], fits};
            end
            else
            begin
                acc_next = {acc_reg[AW-2:0], 1'b0} + (b_reg[BW-1] ? mc_reg : '0);
                b_next   = {b_reg[BW-2:0], 1'b0};
            end
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign result = acc_reg;
    assign done   = done_reg;

endmodule

/* rtl/imu_ca_cordic.sv */
// ----------------------------------------------------------------------------
// imu_ca_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle, with
// left half-plane mirroring. Angle in Q16.16 degrees.
// ----------------------------------------------------------------------------
module imu_ca_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [imu_ca_pkg::CW-1:0]  y_in,
    input  logic signed [imu_ca_pkg::CW-1:0]  x_in,
    output logic signed [imu_ca_pkg::ZW-1:0]  angle,
    output logic signed [imu_ca_pkg::CW-1:0]  mag,
    output logic                              done
);
    import imu_ca_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [4:0]           i_reg,    i_next;
    logic signed [CW-1:0] x_reg,    x_next;
    logic signed [CW-1:0] y_reg,    y_next;
    logic signed [ZW-1:0] z_reg,    z_next;
    logic signed [CW-1:0] dx, dy;

    always_comb
    begin
        dx        = y_reg >>> i_reg;
        dy        = x_reg >>> i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            if (x_in[CW-1])
            begin
                x_next = -x_in;
                y_next = -y_in;
                z_next = y_in[CW-1] ? -DEG180 : DEG180;
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg[CW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_q16(i_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_q16(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;
    assign mag   = x_reg;
    assign done  = done_reg;

endmodule

/* rtl/imu_complementary_attitude.sv */
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// Roll/pitch/yaw complementary filter for a six-axis IMU, Q16.16 degrees.
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives one result. The last calibration
// sample also runs the bias divide. In an update sample every rate-times-time
// term is a serial multiply plus a serial divide, each blend two serial
// multiplies, and each atan2 a 23-step CORDIC. The result sits in an output
// register, so the next sample may enter while it waits.
module imu_complementary_attitude #(
    parameter int CAL_SAMPLES = imu_ca_pkg::CAL_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    imu_ca_stream_if.sink                   sample,
    imu_ca_stream_if.source                 result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [imu_ca_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import imu_ca_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECIDE    = 5'd1;
    localparam logic [4:0] S_CAL_DIV   = 5'd2;
    localparam logic [4:0] S_YAW_MUL   = 5'd3;
    localparam logic [4:0] S_YAW_DIV   = 5'd4;
    localparam logic [4:0] S_ROLL_COR  = 5'd5;
    localparam logic [4:0] S_HYP_MUL   = 5'd6;
    localparam logic [4:0] S_PITCH_COR = 5'd7;
    localparam logic [4:0] S_GX_MUL    = 5'd8;
    localparam logic [4:0] S_GX_DIV    = 5'd9;
    localparam logic [4:0] S_GY_MUL    = 5'd10;
    localparam logic [4:0] S_GY_DIV    = 5'd11;
    localparam logic [4:0] S_RB_A      = 5'd12;
    localparam logic [4:0] S_RB_B      = 5'd13;
    localparam logic [4:0] S_PB_A      = 5'd14;
    localparam logic [4:0] S_PB_B      = 5'd15;
    localparam logic [4:0] S_DONE      = 5'd16;

    localparam logic [7:0]    CAL_LAST = 8'(CAL_SAMPLES - 1);
    localparam logic [7:0]    CAL_N    = 8'(CAL_SAMPLES);
    localparam logic [AW-1:0] CAL_HALF = AW'(CAL_SAMPLES / 2);
    localparam logic [AW-1:0] HALF_LSB = AW'(32768);

    logic [4:0]            state_reg,   state_next;
    logic [16:0]           alpha_reg,   alpha_next;
    logic [31:0]           maxdt_reg,   maxdt_next;
    logic [7:0]            cal_cnt_reg, cal_cnt_next;
    logic signed [23:0]    gz_sum_reg,  gz_sum_next;
    logic signed [31:0]    bias_reg,    bias_next;
    logic signed [31:0]    roll_reg,    roll_next;
    logic signed [31:0]    pitch_reg,   pitch_next;
    logic [31:0]           yaw_reg,     yaw_next;
    logic                  seeded_reg,  seeded_next;
    logic                  cal_f_reg,   cal_f_next;
    logic                  step_f_reg,  step_f_next;
    logic                  tilt_f_reg,  tilt_f_next;
    logic                  ovalid_reg,  ovalid_next;
    sample_t               smp_reg,     smp_next;
    result_t               res_reg,     res_next;
    logic signed [ZW-1:0]  rtilt_reg,   rtilt_next;
    logic signed [ZW-1:0]  ptilt_reg,   ptilt_next;
    logic signed [40:0]    rpred_reg,   rpred_next;
    logic signed [40:0]    ppred_reg,   ppred_next;
    logic [AW-1:0]         sum_reg,     sum_next;

    md_ctl_t               md_ctl;
    logic [AW-1:0]         md_a;
    logic [BW-1:0]         md_b;
    logic [AW-1:0]         md_res;
    logic                  md_done;
    logic                  cor_start;
    logic signed [CW-1:0]  cor_y, cor_x, cor_mag;
    logic signed [ZW-1:0]  cor_z;
    logic                  cor_done;

    logic                  accept;
    logic                  load_out;
    logic signed [23:0]    cal_sum;
    logic [23:0]           cal_mag;
    logic signed [33:0]    rate;
    logic [33:0]           rate_mag;
    logic [16:0]           gx_ext, gy_ext, gx_mag, gy_mag, nax;
    logic [31:0]           dq32;
    logic [31:0]           bias_q;
    logic signed [40:0]    term, sterm;
    logic [16:0]           a_w, b_w;
    logic [AW-1:0]         total, hyp_sum;
    logic [55:0]           blend_v;
    logic [31:0]           blend_sat;
    logic                  dt_ok;
    logic                  tilt_ok;

    imu_ca_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (md_ctl),
        .op_a   (md_a),
        .op_b   (md_b),
        .result (md_res),
        .done   (md_done)
    );

    imu_ca_cordic u_cor (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .y_in   (cor_y),
        .x_in   (cor_x),
        .angle  (cor_z),
        .mag    (cor_mag),
        .done   (cor_done)
    );

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_STEP) ? maxdt_reg : {15'b0, alpha_reg};
    assign sample.ready = (state_reg == S_IDLE);
    assign result.valid = ovalid_reg;
    assign result.data  = res_reg;
    assign accept       = sample.valid && (state_reg == S_IDLE);
    assign load_out     = (state_reg == S_DONE) && (!ovalid_reg || result.ready);

    always_comb
    begin
        cal_sum   = gz_sum_reg + {{8{smp_reg.gyro_z[15]}}, smp_reg.gyro_z};
        cal_mag   = cal_sum[23] ? 24'(-cal_sum) : cal_sum;
        rate      = {{2{smp_reg.gyro_z[15]}}, smp_reg.gyro_z, 16'b0}
                    - {{2{bias_reg[31]}}, bias_reg};
        rate_mag  = rate[33] ? 34'(-rate) : rate;
        gx_ext    = {smp_reg.gyro_x[15], smp_reg.gyro_x};
        gy_ext    = {smp_reg.gyro_y[15], smp_reg.gyro_y};
        gx_mag    = gx_ext[16] ? 17'(-gx_ext) : gx_ext;
        gy_mag    = gy_ext[16] ? 17'(-gy_ext) : gy_ext;
        nax       = 17'(-{smp_reg.accel_x[15], smp_reg.accel_x});
        dq32      = md_res[31:0];
        bias_q    = gz_sum_reg[23] ? 32'(-dq32) : dq32;
        term      = md_res[40:0];
        a_w       = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        b_w       = ALPHA_ONE - a_w;
        total     = sum_reg + md_res + HALF_LSB;
        blend_v   = total[AW-1:16];
        hyp_sum   = md_res + HALF_LSB;
        dt_ok     = (smp_reg.elapsed_us != '0) && (smp_reg.elapsed_us <= maxdt_reg);
        tilt_ok   = (smp_reg.accel_y != '0) || (smp_reg.accel_z != '0);
        if ((&blend_v[55:31]) || (~|blend_v[55:31]))
        begin
            blend_sat = blend_v[31:0];
        end
        else
        begin
            blend_sat = blend_v[55] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (state_reg == S_GX_DIV)
        begin
            sterm = gx_ext[16] ? -term : term;
        end
        else
        begin
            sterm = gy_ext[16] ? -term : term;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        alpha_next   = alpha_reg;
        maxdt_next   = maxdt_reg;
        cal_cnt_next = cal_cnt_reg;
        gz_sum_next  = gz_sum_reg;
        bias_next    = bias_reg;
        roll_next    = roll_reg;
        pitch_next   = pitch_reg;
        yaw_next     = yaw_reg;
        seeded_next  = seeded_reg;
        cal_f_next   = cal_f_reg;
        step_f_next  = step_f_reg;
        tilt_f_next  = tilt_f_reg;
        smp_next     = smp_reg;
        res_next     = res_reg;
        rtilt_next   = rtilt_reg;
        ptilt_next   = ptilt_reg;
        rpred_next   = rpred_reg;
        ppred_next   = ppred_reg;
        sum_next     = sum_reg;
        md_ctl       = '0;
        md_a         = '0;
        md_b         = '0;
        cor_start    = 1'b0;
        cor_y        = '0;
        cor_x        = '0;

        if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_ALPHA)
            begin
                alpha_next = pwdata[16:0];
            end
            else
            begin
                maxdt_next = pwdata;
            end
        end

        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    smp_next    = sample.data;
                    cal_f_next  = 1'b0;
                    step_f_next = 1'b0;
                    tilt_f_next = 1'b0;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (cal_cnt_reg < CAL_N)
                begin
                    cal_f_next   = 1'b1;
                    gz_sum_next  = cal_sum;
                    cal_cnt_next = cal_cnt_reg + 1'b1;
                    if (cal_cnt_reg == CAL_LAST)
                    begin
                        md_ctl     = '{start: 1'b1, is_div: 1'b1};
                        md_a       = {32'b0, cal_mag, 16'b0} + CAL_HALF;
                        md_b       = BW'(CAL_N);
                        state_next = S_CAL_DIV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (dt_ok)
                begin
                    step_f_next = 1'b1;
                    md_ctl      = '{start: 1'b1, is_div: 1'b0};
                    md_a        = {38'b0, rate_mag};
                    md_b        = smp_reg.elapsed_us;
                    state_next  = S_YAW_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CAL_DIV:
            begin
                if (md_done)
                begin
                    bias_next  = bias_q;
                    state_next = S_DONE;
                end
            end
            S_YAW_MUL, S_GX_MUL, S_GY_MUL:
            begin
                if (md_done)
                begin
                    md_ctl     = '{start: 1'b1, is_div: 1'b1};
                    md_a       = md_res + {45'b0, RATE_HALF};
                    md_b       = {5'b0, RATE_DIV};
                    state_next = state_reg + 1'b1;
                end
            end
            S_YAW_DIV:
            begin
                if (md_done)
                begin
                    yaw_next = rate[33] ? yaw_reg - dq32 : yaw_reg + dq32;
                    if (tilt_ok)
                    begin
                        tilt_f_next = 1'b1;
                        cor_start   = 1'b1;
                        cor_y       = {{4{smp_reg.accel_y[15]}}, smp_reg.accel_y, 14'b0};
                        cor_x       = {{4{smp_reg.accel_z[15]}}, smp_reg.accel_z, 14'b0};
                        state_next  = S_ROLL_COR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ROLL_COR:
            begin
                if (cor_done)
                begin
                    rtilt_next = cor_z;
                    md_ctl     = '{start: 1'b1, is_div: 1'b0};
                    md_a       = {{(AW-CW){cor_mag[CW-1]}}, cor_mag};
                    md_b       = {16'b0, INV_GAIN};
                    state_next = S_HYP_MUL;
                end
            end
            S_HYP_MUL:
            begin
                if (md_done)
                begin
                    cor_start  = 1'b1;
                    cor_y      = {{3{nax[16]}}, nax, 14'b0};
                    cor_x      = hyp_sum[16+CW-1:16];
                    state_next = S_PITCH_COR;
                end
            end
            S_PITCH_COR:
            begin
                if (cor_done)
                begin
                    ptilt_next = cor_z;
                    if (!seeded_reg)
                    begin
                        roll_next   = {{(32-ZW){rtilt_reg[ZW-1]}}, rtilt_reg};
                        pitch_next  = {{(32-ZW){cor_z[ZW-1]}}, cor_z};
                        seeded_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        md_ctl     = '{start: 1'b1, is_div: 1'b0};
                        md_a       = {39'b0, gx_mag, 16'b0};
                        md_b       = smp_reg.elapsed_us;
                        state_next = S_GX_MUL;
                    end
                end
            end
            S_GX_DIV:
            begin
                if (md_done)
                begin
                    rpred_next = {{9{roll_reg[31]}}, roll_reg} + sterm;
                    md_ctl     = '{start: 1'b1, is_div: 1'b0};
                    md_a       = {39'b0, gy_mag, 16'b0};
                    md_b       = smp_reg.elapsed_us;
                    state_next = S_GY_MUL;
                end
            end
            S_GY_DIV:
            begin
                if (md_done)
                begin
                    ppred_next = {{9{pitch_reg[31]}}, pitch_reg} + sterm;
                    md_ctl     = '{start: 1'b1, is_div: 1'b0};
                    md_a       = {{(AW-41){rpred_reg[40]}}, rpred_reg};
                    md_b       = {15'b0, a_w};
                    state_next = S_RB_A;
                end
            end
            S_RB_A:
            begin
                if (md_done)
                begin
                    sum_next   = md_res;
                    md_ctl     = '{start: 1'b1, is_div: 1'b0};
                    md_a       = {{(AW-ZW){rtilt_reg[ZW-1]}}, rtilt_reg};
                    md_b       = {15'b0, b_w};
                    state_next = S_RB_B;
                end
            end
            S_RB_B:
            begin
                if (md_done)
                begin
                    roll_next  = blend_sat;
                    md_ctl     = '{start: 1'b1, is_div: 1'b0};
                    md_a       = {{(AW-41){ppred_reg[40]}}, ppred_reg};
                    md_b       = {15'b0, a_w};
                    state_next = S_PB_A;
                end
            end
            S_PB_A:
            begin
                if (md_done)
                begin
                    sum_next   = md_res;
                    md_ctl     = '{start: 1'b1, is_div: 1'b0};
                    md_a       = {{(AW-ZW){ptilt_reg[ZW-1]}}, ptilt_reg};
                    md_b       = {15'b0, b_w};
                    state_next = S_PB_B;
                end
            end
            S_PB_B:
            begin
                if (md_done)
                begin
                    pitch_next = blend_sat;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    res_next    = '{roll_angle:   roll_reg,
                                    pitch_angle:  pitch_reg,
                                    yaw_angle:    yaw_reg,
                                    calibrating:  cal_f_reg,
                                    step_taken:   step_f_reg,
                                    tilt_updated: tilt_f_reg};
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            alpha_reg   <= ALPHA_RESET;
            maxdt_reg   <= STEP_RESET;
            cal_cnt_reg <= '0;
            gz_sum_reg  <= '0;
            bias_reg    <= '0;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            seeded_reg  <= 1'b0;
            cal_f_reg   <= 1'b0;
            step_f_reg  <= 1'b0;
            tilt_f_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            alpha_reg   <= alpha_next;
            maxdt_reg   <= maxdt_next;
            cal_cnt_reg <= cal_cnt_next;
            gz_sum_reg  <= gz_sum_next;
            bias_reg    <= bias_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
            yaw_reg     <= yaw_next;
            seeded_reg  <= seeded_next;
            cal_f_reg   <= cal_f_next;
            step_f_reg  <= step_f_next;
            tilt_f_reg  <= tilt_f_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        res_reg   <= res_next;
        rtilt_reg <= rtilt_next;
        ptilt_reg <= ptilt_next;
        rpred_reg <= rpred_next;
        ppred_reg <= ppred_next;
        sum_reg   <= sum_next;
    end

endmodule

/* rtl/imu_ca_checker.sv */
// ----------------------------------------------------------------------------
// imu_ca_checker
// Port-level checks of the attitude filter, bound to the top level.
// ----------------------------------------------------------------------------
module imu_ca_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic calibrating,
    input logic step_taken,
    input logic tilt_updated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous sample in work");

    a_cal_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibrating |-> !step_taken && !tilt_updated)
        else $error("calibration sample reports an update");

    a_tilt_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tilt_updated |-> step_taken)
        else $error("tilt update without a time step");

endmodule

bind imu_complementary_attitude imu_ca_checker u_imu_ca_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .calibrating  (result.data.calibrating),
    .step_taken   (result.data.step_taken),
    .tilt_updated (result.data.tilt_updated)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for imu_complementary_attitude. Samples are queued
// by the stimulus process and offered by a clocked driver with random gaps; a
// clocked monitor applies random backpressure and compares each result,
// field by field, with an attitude predictor updated on every accepted sample.
// ----------------------------------------------------------------------------
module tb;

    import imu_ca_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_ALPHA = {REG_ALPHA, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_STEP  = {REG_STEP, 2'b00};
    localparam int                SETTLE_CYC = 700;

    localparam longint ATAN_DEG [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    imu_ca_stream_if #(.payload_t(sample_t)) smp_if ();
    imu_ca_stream_if #(.payload_t(result_t)) att_if ();

    imu_complementary_attitude dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp_if),
        .result  (att_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state and register copies
    int          cal_cnt;
    int          gz_acc;
    int          gz_off;
    int          roll_q;
    int          pitch_q;
    logic [31:0] yaw_q;
    bit          seeded;
    logic [16:0] alpha_cfg;
    logic [31:0] step_lim;

    sample_t pending_samples[$];
    result_t expected_att[$];
    int      n_err;
    bit      idle_on;
    bit      holding;
    bit      hold_go;
    int      tx_gap;
    int      rx_gap;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_err++;
    endtask

    function automatic int draw_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 6);
        return $urandom_range(50, 1200);
    endfunction

    // round(|v| * dt / 131e6) half up, sign restored
    function automatic longint rate_times_dt(longint v, longint dt);
        longint unsigned m, a, b, qa, ra, r, dv;
        dv = longint'(RATE_DIV);
        m  = (v < 0) ? -v : v;
        a  = m * (dt >> 16);
        b  = m * (dt & 64'hFFFF) + longint'(RATE_HALF);
        qa = a / dv;
        ra = a % dv;
        r  = (qa << 16) + ((ra << 16) + b) / dv;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint tilt_atan2(longint y, longint x, output longint mag);
        longint z, dx, dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic int sat_q16(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic int blend_angle(int est, longint gyro, longint tilt, longint a);
        longint s;
        s = a * (longint'(est) + gyro) + (65536 - a) * tilt + 32768;
        return sat_q16(s >>> 16);
    endfunction

    function automatic void att_predict(sample_t s);
        longint ax, ay, az, gx, gy, gz, dt, rate, sum, m, xo, unused, hyp;
        longint r_acc, p_acc, a;
        result_t e;
        e  = '0;
        ax = s.accel_x;
        ay = s.accel_y;
        az = s.accel_z;
        gx = s.gyro_x;
        gy = s.gyro_y;
        gz = s.gyro_z;
        dt = longint'(s.elapsed_us);
        if (cal_cnt < CAL_SAMPLES_DEF)
        begin
            e.calibrating = 1'b1;
            gz_acc = gz_acc + int'(gz);
            cal_cnt++;
            if (cal_cnt == CAL_SAMPLES_DEF)
            begin
                sum = longint'(gz_acc) * 65536;
                m = (sum < 0) ? -sum : sum;
                m = (m + CAL_SAMPLES_DEF / 2) / CAL_SAMPLES_DEF;
                gz_off = int'((sum < 0) ? -m : m);
            end
        end
        else if (dt != 0 && dt <= longint'(step_lim))
        begin
            e.step_taken = 1'b1;
            rate = gz * 65536 - longint'(gz_off);
            yaw_q = yaw_q + 32'(rate_times_dt(rate, dt));
            if (ay != 0 || az != 0)
            begin
                e.tilt_updated = 1'b1;
                r_acc = tilt_atan2(ay * 16384, az * 16384, xo);
                hyp   = (xo * longint'(INV_GAIN) + 32768) >>> 16;
                p_acc = tilt_atan2(-ax * 16384, hyp, unused);
                if (!seeded)
                begin
                    roll_q  = sat_q16(r_acc);
                    pitch_q = sat_q16(p_acc);
                    seeded  = 1'b1;
                end
                else
                begin
                    a = (alpha_cfg > ALPHA_ONE) ? 65536 : longint'(alpha_cfg);
                    roll_q  = blend_angle(roll_q, rate_times_dt(gx * 65536, dt), r_acc, a);
                    pitch_q = blend_angle(pitch_q, rate_times_dt(gy * 65536, dt), p_acc, a);
                end
            end
        end
        e.roll_angle  = roll_q;
        e.pitch_angle = pitch_q;
        e.yaw_angle   = yaw_q;
        expected_att.push_back(e);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        bit      busy;
        bit      nv;
        sample_t nd;
        if (rst_n)
        begin
            busy = smp_if.valid;
            if (smp_if.valid && smp_if.ready)
            begin
                att_predict(smp_if.data);
                busy = 1'b0;
            end
            if (!busy)
            begin
                nv = 1'b0;
                nd = '0;
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_samples.size() > 0)
                begin
                    nd = pending_samples.pop_front();
                    nv = 1'b1;
                    tx_gap = draw_gap();
                end
                smp_if.valid <= nv;
                if (nv)
                    smp_if.data <= nd;
            end
        end
    end

    // result monitor and backpressure
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (att_if.valid && att_if.ready)
            begin
                got = att_if.data;
                if (expected_att.size() == 0)
                begin
                    $display("unexpected result: yaw %0d", got.yaw_angle);
                    n_err++;
                end
                else
                begin
                    want = expected_att.pop_front();
                    if (got.roll_angle !== want.roll_angle)
                        report("roll_angle", got.roll_angle, want.roll_angle);
                    if (got.pitch_angle !== want.pitch_angle)
                        report("pitch_angle", got.pitch_angle, want.pitch_angle);
                    if (got.yaw_angle !== want.yaw_angle)
                        report("yaw_angle", got.yaw_angle, want.yaw_angle);
                    if (got.calibrating !== want.calibrating)
                        report("calibrating", got.calibrating, want.calibrating);
                    if (got.step_taken !== want.step_taken)
                        report("step_taken", got.step_taken, want.step_taken);
                    if (got.tilt_updated !== want.tilt_updated)
                        report("tilt_updated", got.tilt_updated, want.tilt_updated);
                end
                rx_gap = draw_gap();
            end
            if (holding)
                att_if.ready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap--;
                att_if.ready <= 1'b0;
            end
            else
                att_if.ready <= 1'b1;
        end
    end

    // long receiver hold so the block backs up and stalls its input
    initial
    begin
        holding = 1'b0;
        wait (hold_go);
        repeat (20) @(posedge clk);
        holding <= 1'b1;
        repeat (6000) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        #100000000;
        $display("imu_complementary_attitude regression: fail");
        $finish;
    end

    task automatic apb_write(logic sel, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (sel == REG_ALPHA) ? ADDR_ALPHA : ADDR_STEP;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_ALPHA)
            alpha_cfg = value[16:0];
        else
            step_lim = value;
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || smp_if.valid || expected_att.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int gz,
                                   logic [31:0] dt);
        sample_t s;
        s.accel_x    = 16'(ax);
        s.accel_y    = 16'(ay);
        s.accel_z    = 16'(az);
        s.gyro_x     = 16'(gx);
        s.gyro_y     = 16'(gy);
        s.gyro_z     = 16'(gz);
        s.elapsed_us = dt;
        return s;
    endfunction

    function automatic sample_t noise_sample();
        sample_t s;
        s = sample_t'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            0: s.elapsed_us = '0;
            1: s.elapsed_us = step_lim;
            2: s.elapsed_us = step_lim + 1;
            default: ;
        endcase
        return s;
    endfunction

    // plausible motion: gravity-sized accel, moderate rates, short steps
    function automatic sample_t motion_sample();
        int lim;
        lim = (step_lim > 3000) ? 3000 : int'(step_lim);
        return mk(int'($urandom_range(0, 40000)) - 20000,
                  int'($urandom_range(0, 40000)) - 20000,
                  int'($urandom_range(0, 40000)) - 20000,
                  int'($urandom_range(0, 8000)) - 4000,
                  int'($urandom_range(0, 8000)) - 4000,
                  int'($urandom_range(0, 8000)) - 4000,
                  (lim < 1) ? 32'd1 : 32'($urandom_range(1, lim)));
    endfunction

    task automatic random_phase(logic [16:0] alpha, logic [31:0] lim, int n, bit idle);
        apb_write(REG_ALPHA, {15'd0, alpha});
        apb_write(REG_STEP, lim);
        idle_on = idle;
        for (int i = 0; i < n; i++)
            pending_samples.push_back(($urandom_range(0, 9) < 7) ? motion_sample()
                                                                 : noise_sample());
        settle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        att_if.ready = 1'b0;
        cal_cnt      = 0;
        gz_acc       = 0;
        gz_off       = 0;
        roll_q       = 0;
        pitch_q      = 0;
        yaw_q        = '0;
        seeded       = 1'b0;
        alpha_cfg    = ALPHA_RESET;
        step_lim     = STEP_RESET;
        n_err        = 0;
        idle_on      = 1'b1;
        hold_go      = 1'b0;
        tx_gap       = 0;
        rx_gap       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        apb_write(REG_ALPHA, 32'(ALPHA_RESET));
        apb_write(REG_STEP, STEP_RESET);

        // bias calibration: extremes first, then anything
        pending_samples.push_back(mk(0, 0, 0, 0, 0, 32767, '1));
        pending_samples.push_back(mk(0, 0, 0, 0, 0, -32768, '0));
        for (int i = 2; i < CAL_SAMPLES_DEF; i++)
            pending_samples.push_back(sample_t'({$urandom, $urandom, $urandom, $urandom}));
        settle();

        // level tilt undefined before seeding, then seed, then blends
        pending_samples.push_back(mk(100, 0, 0, 50, -50, 200, 32'd1000));
        pending_samples.push_back(mk(0, 0, 16384, 0, 0, 0, 32'd1000));
        pending_samples.push_back(mk(5000, 3000, 16000, 131, -131, 1310, 32'd0));
        pending_samples.push_back(mk(5000, 3000, 16000, 131, -131, 1310, STEP_RESET));
        pending_samples.push_back(mk(5000, 3000, 16000, 131, -131, 1310, STEP_RESET + 1));
        pending_samples.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767, 32'd1));
        pending_samples.push_back(mk(32767, -32768, -32768, -32768, 32767, -32768, 32'd2));
        pending_samples.push_back(mk(0, 0, -16384, 0, 0, 0, 32'd500));
        pending_samples.push_back(mk(-32768, 1, -1, 0, 0, 0, 32'd500));
        pending_samples.push_back(mk(32767, -1, -1, 0, 0, 0, 32'd500));
        pending_samples.push_back(mk(0, 16384, 0, 0, 0, 0, 32'd500));
        pending_samples.push_back(mk(0, -16384, 0, 0, 0, 0, 32'd500));
        pending_samples.push_back(mk(0, 0, 0, 32767, 32767, 32767, STEP_RESET));
        pending_samples.push_back(mk(0, 0, 0, -32768, -32768, -32768, STEP_RESET));
        pending_samples.push_back(mk(-32768, -32768, 32767, 1000, 1000, -1000, 32'd99999));
        settle();

        random_phase(17'd0, 32'd1, 15, 1'b1);
        random_phase(ALPHA_ONE, 32'hFFFF_FFFF, 30, 1'b0);
        random_phase(17'h1FFFF, 32'd0, 10, 1'b1);

        hold_go = 1'b1;
        random_phase(17'($urandom_range(0, 65536)), STEP_RESET, 160, 1'b1);
        random_phase(17'($urandom), 32'($urandom_range(1, 5000)), 80, 1'b0);
        random_phase(ALPHA_RESET, STEP_RESET, 90, 1'b1);

        if (n_err == 0 && expected_att.size() == 0)
            $display("imu_complementary_attitude regression: pass");
        else
            $display("imu_complementary_attitude regression: fail");
        $finish;
    end

endmodule
